// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed outside reset");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/knps_pkg.sv =====
// Types and constants shared by the nearest point selector modules.
package knps_pkg;

  localparam int ID_W       = 16;
  localparam int MAXT_W     = 7;
  localparam int CFG_ADDR_W = 2;

  localparam logic [MAXT_W-1:0] MAXT_RESET = 7'd6;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TARGETS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z    = 2'd3;

  typedef struct packed {
    logic accept;
    logic start_pass;
    logic scan;
    logic emit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_in;
    logic pipe_last;
    logic all_done;
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/knps_dist_pipe.sv =====
// Two-stage pipeline that turns a point into its squared distance from the origin.
module knps_dist_pipe import knps_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic [ID_W-1:0]              in_id,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] origin_z,
  output logic                         wr_valid,
  output logic                         wr_last,
  output logic [ID_W-1:0]              wr_id,
  output logic [2*COORD_BITS+1:0]      wr_dist
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic [ID_W-1:0]          s1_id_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [DIFF_W-1:0] dz_r;

  logic                     s2_valid_r;
  logic                     s2_last_r;
  logic [ID_W-1:0]          s2_id_r;
  logic [DIST_W-1:0]        sqx_r;
  logic [DIST_W-1:0]        sqy_r;
  logic [DIST_W-1:0]        sqz_r;

  logic signed [DIST_W-1:0] sqx_nxt;
  logic signed [DIST_W-1:0] sqy_nxt;
  logic signed [DIST_W-1:0] sqz_nxt;

  always_comb begin
    sqx_nxt = dx_r * dx_r;
    sqy_nxt = dy_r * dy_r;
    sqz_nxt = dz_r * dz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_last;
    s1_id_r   <= in_id;
    dx_r      <= DIFF_W'(pos_x) - DIFF_W'(origin_x);
    dy_r      <= DIFF_W'(pos_y) - DIFF_W'(origin_y);
    dz_r      <= DIFF_W'(pos_z) - DIFF_W'(origin_z);
    s2_last_r <= s1_last_r;
    s2_id_r   <= s1_id_r;
    sqx_r     <= $unsigned(sqx_nxt);
    sqy_r     <= $unsigned(sqy_nxt);
    sqz_r     <= $unsigned(sqz_nxt);
  end

  assign wr_valid = s2_valid_r;
  assign wr_last  = s2_last_r;
  assign wr_id    = s2_id_r;
  assign wr_dist  = sqx_r + sqy_r + sqz_r;

endmodule

// ===== rtl/knps_datapath.sv =====
// Datapath: configuration registers, point memory, selection scan and output register.
module knps_datapath import knps_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]                      cfg_addr,
  input  logic [COORD_BITS-1:0]                      cfg_wdata,
  input  logic                                       in_tvalid,
  input  logic [((ID_W+3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                       in_tlast,
  input  logic                                       out_tready,
  output logic                                       out_tvalid,
  output logic [ID_W-1:0]                            out_tdata,
  output logic                                       out_tlast,
  input  ctrl_cmd_t                                  cmd,
  output ctrl_sts_t                                  sts
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic [MAXT_W-1:0]            max_targets_r;
  logic signed [COORD_BITS-1:0] origin_x_r;
  logic signed [COORD_BITS-1:0] origin_y_r;
  logic signed [COORD_BITS-1:0] origin_z_r;

  logic                         in_fire;
  logic                         wr_valid;
  logic                         wr_last;
  logic [ID_W-1:0]              wr_id;
  logic [DIST_W-1:0]            wr_dist;
  logic                         wr_en;

  logic [ID_W-1:0]              id_mem [MAX_POINTS];
  logic [DIST_W-1:0]            dist_mem [MAX_POINTS];

  logic [CW-1:0]                count_r;
  logic [MAX_POINTS-1:0]        taken_r;
  logic [MAXT_W-1:0]            pass_r;
  logic [MAXT_W-1:0]            pass_inc;
  logic [CW-1:0]                scan_idx_r;
  logic                         rd_valid_r;
  logic [AW-1:0]                rd_idx_r;
  logic [ID_W-1:0]              rd_id_r;
  logic [DIST_W-1:0]            rd_dist_r;
  logic                         best_found_r;
  logic [DIST_W-1:0]            best_dist_r;
  logic [ID_W-1:0]              best_id_r;
  logic [AW-1:0]                best_idx_r;
  logic                         out_valid_r;
  logic [ID_W-1:0]              out_id_r;
  logic                         out_last_r;

  logic                         all_mode;
  logic [MAXT_W-1:0]            total;
  logic [CW-1:0]                scan_start;
  logic [CW-1:0]                scan_end;
  logic                         take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_targets_r <= MAXT_RESET;
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      origin_z_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MAX_TARGETS: max_targets_r <= cfg_wdata[MAXT_W-1:0];
        REG_ORIGIN_X:    origin_x_r    <= cfg_wdata;
        REG_ORIGIN_Y:    origin_y_r    <= cfg_wdata;
        REG_ORIGIN_Z:    origin_z_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_fire = in_tvalid && cmd.accept;

  knps_dist_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_knps_dist_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .in_last  (in_tlast),
    .in_id    (in_tdata[ID_W-1:0]),
    .pos_x    (in_tdata[ID_W +: COORD_BITS]),
    .pos_y    (in_tdata[ID_W+COORD_BITS +: COORD_BITS]),
    .pos_z    (in_tdata[ID_W+2*COORD_BITS +: COORD_BITS]),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .origin_z (origin_z_r),
    .wr_valid (wr_valid),
    .wr_last  (wr_last),
    .wr_id    (wr_id),
    .wr_dist  (wr_dist)
  );

  // A point that arrives with the memory full is dropped.
  assign wr_en = wr_valid && (count_r < CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[count_r[AW-1:0]]   <= wr_id;
      dist_mem[count_r[AW-1:0]] <= wr_dist;
    end
    if (cmd.scan) begin
      rd_id_r   <= id_mem[scan_idx_r[AW-1:0]];
      rd_dist_r <= dist_mem[scan_idx_r[AW-1:0]];
    end
  end

  always_comb begin
    all_mode   = MAXT_W'(count_r) <= max_targets_r;
    total      = all_mode ? MAXT_W'(count_r) : max_targets_r;
    pass_inc   = pass_r + MAXT_W'(1);
    scan_start = all_mode ? CW'(pass_r) : '0;
    scan_end   = all_mode ? CW'(pass_r) : count_r - CW'(1);
    take       = rd_valid_r && !taken_r[rd_idx_r] &&
                 (!best_found_r || (rd_dist_r < best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      taken_r      <= '0;
      pass_r       <= '0;
      scan_idx_r   <= '0;
      rd_valid_r   <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan;
      if (cmd.clear) begin
        count_r <= '0;
        taken_r <= '0;
        pass_r  <= '0;
      end else begin
        if (wr_en) begin
          count_r <= count_r + CW'(1);
        end
        if (cmd.emit) begin
          taken_r[best_idx_r] <= 1'b1;
          pass_r              <= pass_inc;
        end
      end
      if (cmd.start_pass) begin
        scan_idx_r <= scan_start;
      end else if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      if (cmd.start_pass) begin
        best_found_r <= 1'b0;
      end else if (take) begin
        best_found_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r[AW-1:0];
    if (take) begin
      best_dist_r <= rd_dist_r;
      best_id_r   <= rd_id_r;
      best_idx_r  <= rd_idx_r;
    end
    if (cmd.emit) begin
      out_id_r   <= best_id_r;
      out_last_r <= (pass_inc == total);
    end
  end

  always_comb begin
    sts.last_in   = in_fire && in_tlast;
    sts.pipe_last = wr_valid && wr_last;
    sts.all_done  = (pass_r == total);
    sts.scan_last = (scan_idx_r == scan_end);
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/knps_ctrl.sv =====
// Controller state machine that sequences loading, selection passes and output.
module knps_ctrl import knps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_DRAIN  = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_WAIT   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.accept = 1'b1;
        if (sts.last_in) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.all_done) begin
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          cmd.start_pass = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/k_nearest_point_selector.sv =====
// Points stream in one word per clock while the input is open and are stored with their
// squared distance from the origin, computed in a two-stage pipeline; the word marked tlast
// closes the set, and up to MAX_POINTS points are kept, later ones being dropped. Selection
// starts once the marked word has left the distance pipeline. If the set holds no more points
// than max_targets every id is returned in load order; otherwise max_targets ids come nearest
// first, ties to the earlier point, every pass reading each stored entry of the point memory
// once. The input is closed from the marked word until the controller returns to loading
// after the final result has been placed in the output register; a stalled output holds the
// sequencer.
module k_nearest_point_selector import knps_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
  input  logic [COORD_BITS-1:0]                  cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: point_id, pos_x, pos_y, pos_z, zero fill.
  input  logic [((ID_W+3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: chosen_id.
  output logic [ID_W-1:0]                        out_tdata,
  output logic                                   out_tlast
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  knps_ctrl u_knps_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  knps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_knps_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign in_tready = cmd.accept;

endmodule

// ===== rtl/knps_checker.sv =====
// Port-level checker for the nearest point selector and its bind statement.
`include "assert_macros.svh"

module knps_checker import knps_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic            in_tlast,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [ID_W-1:0] out_tdata,
  input logic            out_tlast
);

  // The block is ready for points right after reset.
  `ASSERT_ALWAYS(a_ready_after_reset, clk, !rst_n |=> in_tready)

  // A set closes at its marked word.
  `ASSERT_RUN(a_close_on_last, clk, rst_n, in_tvalid && in_tready && in_tlast |=> !in_tready)

  // Results other than the final one only appear while input is closed.
  `ASSERT_RUN(a_no_load_mid_run, clk, rst_n, out_tvalid && !out_tlast |-> !in_tready)

  // A stalled result holds.
  `ASSERT_RUN(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind k_nearest_point_selector knps_checker u_knps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the k nearest point selector.
module testbench;
  import knps_pkg::*;

  localparam int MAX_PTS    = 64;
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int TDATA_W    = ((ID_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int SETTLE     = MAX_PTS + 16;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 120;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    coord_t          x;
    coord_t          y;
    coord_t          z;
    logic            last;
  } point_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } pick_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    point_t                 pt;
    logic [CFG_ADDR_W-1:0]  addr;
    logic [COORD_W-1:0]     value;
    bit                     typed;
    logic [ID_W-1:0]        typed_id;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [COORD_W-1:0]    cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [ID_W-1:0]       out_tdata;
  logic                  out_tlast;

  k_nearest_point_selector #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  logic [ID_W-1:0]   stored_ids  [MAX_PTS];
  logic [DIST_W-1:0] stored_dist [MAX_PTS];
  int unsigned       stored_n;
  logic [MAXT_W-1:0] cur_max_targets;
  coord_t            cur_org_x;
  coord_t            cur_org_y;
  coord_t            cur_org_z;

  pick_t expected_picks[$];
  pick_t ranked[$];
  row_t  stimulus_rows[$];

  int errors;
  int ids_checked;
  int points_sent;
  int sets_sent;
  int reg_writes;
  int quiet_cycles;
  bit calm;
  bit settled;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [DIST_W-1:0] sq_offset(coord_t p, coord_t o);
    logic signed [DIFF_W-1:0] d;
    logic [DIST_W-1:0]        mag;
    d   = DIFF_W'(p) - DIFF_W'(o);
    mag = DIST_W'(d);
    if (d < 0) mag = -mag;
    return mag * mag;
  endfunction

  // Stores one point and, on the marked point, fills ranked with the chosen ids.
  function automatic void pick_nearest(point_t p);
    bit    taken [MAX_PTS];
    bit    found;
    int    best;
    pick_t pk;
    ranked.delete();
    if (stored_n < MAX_PTS) begin
      stored_ids[stored_n]  = p.id;
      stored_dist[stored_n] = sq_offset(p.x, cur_org_x) + sq_offset(p.y, cur_org_y)
                              + sq_offset(p.z, cur_org_z);
      stored_n++;
    end
    if (!p.last) return;
    if (stored_n <= cur_max_targets) begin
      for (int i = 0; i < stored_n; i++) begin
        pk = {stored_ids[i], 1'b0};
        ranked.push_back(pk);
      end
    end else begin
      for (int k = 0; k < cur_max_targets; k++) begin
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < stored_n; i++) begin
          if (!taken[i] && (!found || stored_dist[i] < stored_dist[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) break;
        taken[best] = 1'b1;
        pk = {stored_ids[best], 1'b0};
        ranked.push_back(pk);
      end
    end
    if (ranked.size() > 0) ranked[ranked.size()-1].last = 1'b1;
    stored_n = 0;
  endfunction

  function automatic void add_point(logic [ID_W-1:0] id, coord_t x, coord_t y, coord_t z,
                                    logic last, bit typed = 1'b0,
                                    logic [ID_W-1:0] typed_id = '0);
    row_t r;
    r.kind     = ROW_POINT;
    r.pt       = {id, x, y, z, last};
    r.addr     = REG_MAX_TARGETS;
    r.value    = '0;
    r.typed    = typed;
    r.typed_id = typed_id;
    stimulus_rows.push_back(r);
  endfunction

  function automatic void add_write(logic [CFG_ADDR_W-1:0] addr, logic [COORD_W-1:0] value);
    row_t r;
    r.kind     = ROW_WRITE;
    r.pt       = '0;
    r.addr     = addr;
    r.value    = value;
    r.typed    = 1'b0;
    r.typed_id = '0;
    stimulus_rows.push_back(r);
  endfunction

  function automatic coord_t rand_coord(coord_t o);
    int off;
    off = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return o + coord_t'(off);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic drain_and_settle();
    if (!settled) begin
      in_tvalid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      settled = 1'b1;
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [COORD_W-1:0] value);
    drain_and_settle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      REG_MAX_TARGETS: cur_max_targets = value[MAXT_W-1:0];
      REG_ORIGIN_X:    cur_org_x = value;
      REG_ORIGIN_Y:    cur_org_y = value;
      REG_ORIGIN_Z:    cur_org_z = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic offer_point(point_t p, bit typed, logic [ID_W-1:0] typed_id);
    int    gap;
    pick_t pk;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({p.z, p.y, p.x, p.id});
    in_tlast  <= p.last;
    do @(posedge clk); while (!in_tready);
    settled = 1'b0;
    points_sent++;
    if (p.last) sets_sent++;
    pick_nearest(p);
    if (typed) begin
      pk = {typed_id, 1'b1};
      expected_picks.push_back(pk);
    end else begin
      foreach (ranked[i]) expected_picks.push_back(ranked[i]);
    end
  endtask

  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      ids_checked++;
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected word, id %h last %b", out_tdata, out_tlast));
      end else begin
        want = expected_picks.pop_front();
        if (out_tdata !== want.id)
          report_mismatch($sformatf("chosen id %h, expected %h", out_tdata, want.id));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last flag %b on id %h, expected %b",
                                    out_tlast, out_tdata, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    point_t            p;
    logic [MAXT_W-1:0] mt;
    int                rand_points;
    int                ph;
    int                nsets;
    int                len;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tlast        = 1'b0;
    out_tready      = 1'b0;
    errors          = 0;
    ids_checked     = 0;
    points_sent     = 0;
    sets_sent       = 0;
    reg_writes      = 0;
    quiet_cycles    = 0;
    calm            = 1'b0;
    settled         = 1'b0;
    hold_req        = 1'b0;
    stored_n        = 0;
    cur_max_targets = MAXT_RESET;
    cur_org_x       = '0;
    cur_org_y       = '0;
    cur_org_z       = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_point(16'hFFFF, C_MAX, 0, 0, 1'b1, 1'b1, 16'hFFFF);
    add_point(16'h0001, 1, 1, 1, 1'b0);
    add_point(16'h0002, 0, 0, 0, 1'b0);
    add_point(16'h0003, -1, -1, -1, 1'b1);
    add_write(REG_MAX_TARGETS, 24'd3);
    add_point(16'h0010, 5, 0, 0, 1'b0);
    add_point(16'h0011, 0, -5, 0, 1'b0);
    add_point(16'h0012, 0, 0, 3, 1'b0);
    add_point(16'h0013, C_MIN, C_MIN, C_MIN, 1'b0);
    add_point(16'h0012, 0, 0, 3, 1'b1);
    add_write(REG_ORIGIN_X, C_MIN);
    add_write(REG_ORIGIN_Y, C_MAX);
    add_write(REG_ORIGIN_Z, C_MIN);
    add_point(16'h0020, C_MAX, C_MIN, C_MAX, 1'b0);
    add_point(16'h0021, C_MIN, C_MAX, C_MIN, 1'b0);
    add_point(16'h0022, 0, 0, 0, 1'b0);
    add_point(16'h0023, C_MAX, C_MAX, C_MAX, 1'b1);
    add_write(REG_MAX_TARGETS, 24'd0);
    add_point(16'h0030, 1, 2, 3, 1'b0);
    add_point(16'h0031, 4, 5, 6, 1'b1);
    add_point(16'h0040, 7, 7, 7, 1'b0);
    add_write(REG_MAX_TARGETS, 24'd1);
    add_point(16'h0041, C_MIN, C_MAX, C_MIN, 1'b1, 1'b1, 16'h0041);
    add_write(REG_MAX_TARGETS, 24'd127);
    add_point(16'h0000, -1, 0, 1, 1'b1, 1'b1, 16'h0000);

    foreach (stimulus_rows[i]) begin
      if (stimulus_rows[i].kind == ROW_WRITE)
        write_reg(stimulus_rows[i].addr, stimulus_rows[i].value);
      else
        offer_point(stimulus_rows[i].pt, stimulus_rows[i].typed, stimulus_rows[i].typed_id);
    end

    rand_points = 0;
    ph          = 0;
    while (rand_points < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       mt = '0;
        1:       mt = MAXT_W'(1);
        2:       mt = MAXT_W'(MAX_PTS);
        3:       mt = MAXT_W'($urandom_range(MAX_PTS + 1, 127));
        default: mt = MAXT_W'($urandom_range(2, 12));
      endcase
      if (ph == 0 && mt == '0) mt = MAXT_W'(2);
      if (ph == 1) mt = MAXT_W'(3);
      write_reg(REG_MAX_TARGETS, COORD_W'(mt));
      write_reg(REG_ORIGIN_X, rand_coord('0));
      write_reg(REG_ORIGIN_Y, rand_coord('0));
      write_reg(REG_ORIGIN_Z, rand_coord('0));
      calm = ($urandom_range(0, 3) == 0);
      if (ph == 0) hold_req = 1'b1;
      nsets = (ph == 0) ? 4 : int'($urandom_range(2, 4));
      for (int s = 0; s < nsets; s++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        if (s == 0 && ph == 1) len = MAX_PTS + 1;
        for (int i = 0; i < len; i++) begin
          p.id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
          p.x    = rand_coord(cur_org_x);
          p.y    = rand_coord(cur_org_y);
          p.z    = rand_coord(cur_org_z);
          p.last = (i == len - 1);
          offer_point(p, 1'b0, '0);
          rand_points++;
        end
      end
      ph++;
    end

    in_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d points in %0d sets over %0d register writes; %0d chosen ids checked.",
             points_sent, sets_sent, reg_writes, ids_checked);
    $display("Covered load-order and ranked output, ties, a full store and a long output stall.");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
